[design/slot_free_list_allocator_core_assert.svh]
// Assertion macros shared by the allocator RTL.
// SFLA_ASSERT_HOLDS checks a condition at every clock edge out of reset.
// SFLA_ASSERT_IMPLIES checks that a trigger condition implies a consequence.
`ifndef SLOT_FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH
`define SLOT_FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define SFLA_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);
`define SFLA_ASSERT_IMPLIES(label, trig, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |-> (cons)) \
        else $error(msg);
`else
`define SFLA_ASSERT_HOLDS(label, cond, msg)
`define SFLA_ASSERT_IMPLIES(label, trig, cons, msg)
`endif

`endif

[design/sfla_pkg.sv]
`default_nettype none

package sfla_pkg;

    localparam int SLOTS_DEF  = 32;
    localparam int ID_W       = 5;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 6;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 16;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 2'd0,
        ST_EXHAUSTED   = 2'd1,
        ST_DOUBLE_FREE = 2'd2,
        ST_RANGE       = 2'd3
    } status_t;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } command_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;        // capture the accepted transaction
        logic    rd_top;      // read the top of the stack
        logic    scan_first;  // read stack entry 0
        logic    scan_next;   // read the next stack entry
        logic    pop;         // hand out the top entry
        logic    push;        // write the freed index on top
        logic    set_st;      // record an error code
        status_t st_code;
        logic    out_load;    // move the result into the output register
    } ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_free;     // the held command is a free
        logic depth_zero;  // no free slot
        logic depth_full;  // every slot free
        logic id_range;    // held index is not below SLOTS
        logic match;       // entry under scan equals the held index
        logic scan_last;   // entry under scan is the top of the stack
        logic out_busy;    // output register holds a result not yet taken
    } sts_t;

endpackage

`default_nettype wire

[design/sfla_ram.sv]
`default_nettype none

module sfla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[design/sfla_ctrl.sv]
`default_nettype none

module sfla_ctrl
    import sfla_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    input  wire sts_t sts,
    output ctl_t      ctl
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CHECK = 6'b000010,
        S_POP   = 6'b000100,
        S_SCAN  = 6'b001000,
        S_PUSH  = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        ctl        = '0;
        ctl.st_code = ST_OK;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    ctl.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                priority if (!sts.is_free && sts.depth_zero) begin
                    ctl.set_st  = 1'b1;
                    ctl.st_code = ST_EXHAUSTED;
                    state_next  = S_DONE;
                end else if (!sts.is_free) begin
                    ctl.rd_top = 1'b1;
                    state_next = S_POP;
                end else if (sts.id_range) begin
                    ctl.set_st  = 1'b1;
                    ctl.st_code = ST_RANGE;
                    state_next  = S_DONE;
                end else if (sts.depth_full) begin
                    ctl.set_st  = 1'b1;
                    ctl.st_code = ST_DOUBLE_FREE;
                    state_next  = S_DONE;
                end else if (sts.depth_zero) begin
                    state_next = S_PUSH;
                end else begin
                    ctl.scan_first = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_POP: begin
                ctl.pop    = 1'b1;
                state_next = S_DONE;
            end
            S_SCAN: begin
                priority if (sts.match) begin
                    ctl.set_st  = 1'b1;
                    ctl.st_code = ST_DOUBLE_FREE;
                    state_next  = S_DONE;
                end else if (sts.scan_last) begin
                    state_next = S_PUSH;
                end else begin
                    ctl.scan_next = 1'b1;
                end
            end
            S_PUSH: begin
                ctl.push   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!sts.out_busy) begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[design/sfla_datapath.sv]
`default_nettype none
`include "slot_free_list_allocator_core_assert.svh"

module sfla_datapath
    import sfla_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_command,
    input  wire logic [ID_W-1:0]      in_slot_id,
    input  wire ctl_t                 ctl,
    output sts_t                      sts,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic [STATUS_W-1:0]       m_tuser
);

    localparam int DW    = $clog2(SLOTS + 1);
    localparam int IDX_W = $clog2(SLOTS);

    logic             cmd_reg;
    logic [ID_W-1:0]  id_reg;
    logic [DW-1:0]    depth_reg, depth_next;
    logic [DW-1:0]    low_reg, low_next;
    logic [IDX_W-1:0] raddr_reg, raddr_next;
    logic [ID_W-1:0]  grant_reg;
    status_t          st_reg;
    logic             out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic [STATUS_W-1:0]  out_user_reg;

    logic [ID_W-1:0]  ram_q;
    logic [ID_W-1:0]  entry_val;
    logic [DW-1:0]    depth_dec;

    assign depth_dec = depth_reg - 1'b1;

    always_comb begin
        priority if (ctl.rd_top) begin
            raddr_next = IDX_W'(depth_dec);
        end else if (ctl.scan_first) begin
            raddr_next = '0;
        end else if (ctl.scan_next) begin
            raddr_next = raddr_reg + 1'b1;
        end else begin
            raddr_next = raddr_reg;
        end
    end

    sfla_ram #(
        .WIDTH (ID_W),
        .DEPTH (SLOTS)
    ) u_stack (
        .aclk  (aclk),
        .we    (ctl.push),
        .waddr (IDX_W'(depth_reg)),
        .wdata (id_reg),
        .raddr (raddr_next),
        .rdata (ram_q)
    );

    // Entries below the lowest depth ever reached were never written, so their
    // value is taken to be their own index instead of the RAM output.
    assign entry_val = (DW'(raddr_reg) >= low_reg) ? ram_q : ID_W'(raddr_reg);

    always_comb begin
        depth_next = depth_reg;
        low_next   = low_reg;
        if (ctl.pop) begin
            depth_next = depth_dec;
            if (depth_dec < low_reg) begin
                low_next = depth_dec;
            end
        end else if (ctl.push) begin
            depth_next = depth_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg     <= DW'(SLOTS);
            low_reg       <= DW'(SLOTS);
            out_valid_reg <= 1'b0;
        end else begin
            depth_reg <= depth_next;
            low_reg   <= low_next;
            if (ctl.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        raddr_reg <= raddr_next;
        if (ctl.load) begin
            cmd_reg   <= in_command;
            id_reg    <= in_slot_id;
            grant_reg <= '0;
            st_reg    <= ST_OK;
        end
        if (ctl.pop) begin
            grant_reg <= entry_val;
        end
        if (ctl.set_st) begin
            st_reg <= ctl.st_code;
        end
        if (ctl.out_load) begin
            out_data_reg <= {3'b000,
                             (depth_reg == DW'(SLOTS)),
                             (depth_reg == '0),
                             COUNT_W'(depth_reg),
                             grant_reg};
            out_user_reg <= st_reg;
        end
    end

    assign sts.is_free    = (cmd_reg == CMD_FREE);
    assign sts.depth_zero = (depth_reg == '0);
    assign sts.depth_full = (depth_reg == DW'(SLOTS));
    assign sts.id_range   = (32'(id_reg) >= SLOTS);
    assign sts.match      = (entry_val == id_reg);
    assign sts.scan_last  = ((DW'(raddr_reg) + 1'b1) == depth_reg);
    assign sts.out_busy   = out_valid_reg && !m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    `SFLA_ASSERT_HOLDS(a_depth_bound, depth_reg <= DW'(SLOTS), "stack depth above pool size")
    `SFLA_ASSERT_HOLDS(a_low_water, low_reg <= depth_reg, "low-water mark above stack depth")
    `SFLA_ASSERT_IMPLIES(a_pop_nonempty, ctl.pop, depth_reg != '0, "pop from an empty stack")
    `SFLA_ASSERT_IMPLIES(a_push_room, ctl.push, depth_reg < DW'(SLOTS), "push onto a full stack")

endmodule

`default_nettype wire

[design/slot_free_list_allocator_core.sv]
// An allocate passes through CHECK, POP and DONE before its result is registered; a command
// refused at CHECK goes straight to DONE; a free searches the stack in SCAN (skipped when
// it is empty), then goes to PUSH and DONE, or straight to DONE on a match. One transaction
// at a time; the input is ready again in the cycle after the result is loaded.
// The duplicate search reads one stack entry per cycle through the single RAM read port.
// Reset (aresetn, synchronous, active low) makes every slot free at once; no clearing pass.
`default_nettype none

module slot_free_list_allocator_core
    import sfla_pkg::*;
#(
    // Number of slots in the pool; sets the depth of the free stack.
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    // Command input.
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // [4:0] slot_id, [7:5] zero
    input  wire logic                 s_tuser,   // [0] command (0 allocate, 1 free)

    // Result output.
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // [4:0] granted_slot, [10:5] free_count,
                                                 // [11] pool_empty, [12] all_free, [15:13] zero
    output logic [STATUS_W-1:0]       m_tuser    // [1:0] status
);

    // The controller sequences each transaction: it checks the command, then
    // either pops the top of the free stack or scans the stack, if not empty, one entry per
    // cycle looking for the index to be freed before pushing it. The datapath
    // holds the stack RAM, the depth counter and the result register.

    ctl_t ctl;
    sts_t sts;

    sfla_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    // The result register lets the next transaction be accepted while an
    // earlier result still waits for the downstream side.
    sfla_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_command (s_tuser),
        .in_slot_id (s_tdata[ID_W-1:0]),
        .ctl        (ctl),
        .sts        (sts),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

`default_nettype wire

[bench/slot_free_list_allocator_core_tb.sv]
`default_nettype none

module slot_free_list_allocator_core_tb;
    import sfla_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL_SLOTS     = SLOTS_DEF;
    localparam int RANDOM_ITEMS   = 1440;
    localparam int PHASE_LEN      = 120;
    localparam int CYCLE_LIMIT    = 600_000;
    localparam int IDLE_PERCENT   = 33;

    // One expected result: the fields of m_tdata and m_tuser, unpacked.
    typedef struct {
        logic [ID_W-1:0]    granted;
        status_t            status;
        logic [COUNT_W-1:0] count;
        logic               empty;
        logic               full;
    } pool_reply_t;

    // Keeps a private copy of the free stack, predicts the result of every
    // accepted command transaction and checks the results in order.
    class slot_pool_tracker;
        logic [ID_W-1:0] free_ids [POOL_SLOTS];
        int              depth;
        pool_reply_t     replies_due [$];
        int unsigned     mismatches;

        function new();
            for (int k = 0; k < POOL_SLOTS; k++) begin
                free_ids[k] = ID_W'(k);
            end
            depth = POOL_SLOTS;
            mismatches = 0;
        endfunction

        function bit is_free(logic [ID_W-1:0] id);
            for (int k = 0; k < depth; k++) begin
                if (free_ids[k] == id) begin
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        // Returns a slot that is currently handed out, or -1 if none is.
        function int pick_held_slot();
            int held [$];
            for (int id = 0; id < POOL_SLOTS; id++) begin
                if (!is_free(ID_W'(id))) begin
                    held.push_back(id);
                end
            end
            if (held.size() == 0) begin
                return -1;
            end
            return held[$urandom_range(held.size() - 1)];
        endfunction

        function void note_command(command_t cmd, logic [ID_W-1:0] id);
            pool_reply_t r;
            r.granted = '0;
            r.status  = ST_OK;
            if (cmd == CMD_ALLOC) begin
                if (depth == 0) begin
                    r.status = ST_EXHAUSTED;
                end else begin
                    depth = depth - 1;
                    r.granted = free_ids[depth];
                end
            end else begin
                // The range check comes before the duplicate search.
                if (int'(id) >= POOL_SLOTS) begin
                    r.status = ST_RANGE;
                end else if (depth >= POOL_SLOTS || is_free(id)) begin
                    r.status = ST_DOUBLE_FREE;
                end else begin
                    free_ids[depth] = id;
                    depth = depth + 1;
                end
            end
            r.count = depth[COUNT_W-1:0];
            r.empty = (depth == 0);
            r.full  = (depth == POOL_SLOTS);
            replies_due.push_back(r);
        endfunction

        function void check_reply(logic [M_TDATA_W-1:0] data, logic [STATUS_W-1:0] code);
            pool_reply_t want;
            if (replies_due.size() == 0) begin
                $error("result transaction with no expected result waiting");
                mismatches++;
                return;
            end
            want = replies_due.pop_front();
            if (data[4:0] !== want.granted) begin
                $error("granted_slot: expected %0d, actual %0d", want.granted, data[4:0]);
                mismatches++;
            end
            if (code !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, code);
                mismatches++;
            end
            if (data[10:5] !== want.count) begin
                $error("free_count: expected %0d, actual %0d", want.count, data[10:5]);
                mismatches++;
            end
            if (data[11] !== want.empty) begin
                $error("pool_empty: expected %0d, actual %0d", want.empty, data[11]);
                mismatches++;
            end
            if (data[12] !== want.full) begin
                $error("all_free: expected %0d, actual %0d", want.full, data[12]);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return replies_due.size();
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [STATUS_W-1:0]    m_tuser;

    // While calm is set neither side idles, so back-to-back transactions are seen.
    bit                     calm = 1'b0;
    int unsigned            cycle_count = 0;
    slot_pool_tracker       tracker = new();

    slot_free_list_allocator_core #(
        .SLOTS(POOL_SLOTS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #6 aclk = ~aclk;

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // The result side stalls at random, one decision per cycle, made at the
    // falling edge so that the block sees a settled m_tready at the next rising edge.
    always @(negedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Every result transaction is checked against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            tracker.check_reply(m_tdata, m_tuser);
        end
    end

    // Presents one command transaction and returns once it has been accepted.
    // Inputs only change at the falling edge; s_tvalid gets one assignment per step,
    // so a valid that stays high across items is never dropped and raised again.
    task automatic send_command(command_t cmd, logic [ID_W-1:0] id);
        @(negedge aclk);
        while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            s_tdata  <= {S_TDATA_W{1'b0}};
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - ID_W){1'b0}}, id};
        s_tuser  <= cmd;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        tracker.note_command(cmd, id);
    endtask

    // Holds the sender back until every expected result has come out.
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (tracker.outstanding() != 0) begin
            @(posedge aclk);
        end
    endtask

    initial begin
        int alloc_bias;
        int held;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = CMD_ALLOC;
        m_tready = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part. The pool starts full, so a free of any index is a
        // double free caught by the full-stack guard.
        send_command(CMD_FREE, 5'd31);
        send_command(CMD_FREE, 5'd0);
        // Allocates hand out the top of the stack; the slot_id field is ignored.
        send_command(CMD_ALLOC, 5'd0);
        send_command(CMD_ALLOC, 5'd31);
        send_command(CMD_FREE, 5'd31);
        // Freeing the same slot twice in a row is refused.
        send_command(CMD_FREE, 5'd31);
        // This free makes the pool whole again and raises all_free.
        send_command(CMD_FREE, 5'd30);
        send_command(CMD_FREE, 5'd30);
        // Last in, first out: 30 was freed last so it comes back first.
        send_command(CMD_ALLOC, 5'b10101);
        send_command(CMD_ALLOC, 5'b01010);
        send_command(CMD_ALLOC, 5'd31);
        // Slot 0 sits at the bottom of the stack: the search must reach it.
        send_command(CMD_FREE, 5'd0);
        send_command(CMD_FREE, 5'd28);
        send_command(CMD_FREE, 5'd29);
        send_command(CMD_FREE, 5'd31);
        send_command(CMD_FREE, 5'd30);
        send_command(CMD_ALLOC, 5'd0);
        send_command(CMD_FREE, 5'd31);

        // Let the block go fully idle once before the random part.
        drain_results();

        // Random part. Phases lean toward allocates (which drain the pool and
        // reach exhaustion), toward frees (which refill it) or neither. Most frees
        // return a slot that is actually held; the rest pick any index and so
        // mostly end up as double frees.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            case ((n / PHASE_LEN) % 3)
                0: alloc_bias = 85;
                1: alloc_bias = 15;
                default: alloc_bias = 50;
            endcase
            calm = (n >= 600 && n < 800);
            if (n == 1000) begin
                drain_results();
            end
            if ($urandom_range(99) < alloc_bias) begin
                send_command(CMD_ALLOC, ID_W'($urandom_range(POOL_SLOTS - 1)));
            end else begin
                held = tracker.pick_held_slot();
                if (held >= 0 && $urandom_range(99) < 85) begin
                    send_command(CMD_FREE, held[ID_W-1:0]);
                end else begin
                    send_command(CMD_FREE, ID_W'($urandom_range(POOL_SLOTS - 1)));
                end
            end
        end

        drain_results();
        // Wait for any stray result after the drain.
        repeat (POOL_SLOTS + 10) @(posedge aclk);

        if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
+incdir+design
design/sfla_pkg.sv
design/sfla_ram.sv
design/sfla_ctrl.sv
design/sfla_datapath.sv
design/slot_free_list_allocator_core.sv
bench/slot_free_list_allocator_core_tb.sv
